@@ design/vsg_pkg.sv @@
// vsg_pkg: shared constants, register codes and helper functions of the uv sphere
// vertex generator. No dependencies; imported by every module of the block.
`default_nettype none
package vsg_pkg;

    localparam int MAX_SEGMENTS_DEF = 1024;
    localparam int ANGLE_BITS_DEF   = 16;

    localparam int CNT_W  = 11;
    localparam int RAD_W  = 16;
    localparam int POS_W  = 17;
    localparam int TEX_W  = 17;
    localparam int CFG_IW = 2;

    localparam logic [CFG_IW-1:0] CFG_LON_COUNT = 2'd0;
    localparam logic [CFG_IW-1:0] CFG_LAT_COUNT = 2'd1;
    localparam logic [CFG_IW-1:0] CFG_RADIUS    = 2'd2;

    localparam logic [CNT_W-1:0] LON_COUNT_RST = 11'd32;
    localparam logic [CNT_W-1:0] LAT_COUNT_RST = 11'd16;
    localparam logic [RAD_W-1:0] RADIUS_RST    = 16'd256;

    // quarter-wave sine polynomial coefficients, Q16
    localparam logic [16:0] SIN_A   = 17'd102944;
    localparam logic [16:0] SIN_B   = 17'd42048;
    localparam logic [16:0] SIN_C   = 17'd4640;
    localparam logic [16:0] ONE_Q16 = 17'd65536;

    localparam logic signed [20:0] POS_LIMIT = 21'sd65535;

    function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] n,
                                                   input int unsigned max_seg);
        logic [CNT_W-1:0] res;
        if (n == '0)
            res = 11'd1;
        else if (32'(n) > max_seg)
            res = CNT_W'(max_seg);
        else
            res = n;
        return res;
    endfunction

    function automatic logic [POS_W-1:0] sat_pos(input logic signed [20:0] v);
        logic signed [20:0] s;
        if (v > POS_LIMIT)
            s = POS_LIMIT;
        else if (v < -POS_LIMIT)
            s = -POS_LIMIT;
        else
            s = v;
        return s[POS_W-1:0];
    endfunction

endpackage
`default_nettype wire

@@ design/vsg_div_cell.sv @@
// vsg_div_cell: one restoring division step for the longitude and latitude lanes.
// Depends on vsg_pkg; chained by uv_sphere_vertex_generator.
`default_nettype none
module vsg_div_cell
    import vsg_pkg::*;
#(
    parameter int QW    = 18,
    parameter bit FIRST = 1'b0
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             en,
    input  wire logic             in_valid,
    input  wire logic [CNT_W-1:0] in_rem_i,
    input  wire logic [CNT_W-1:0] in_rem_j,
    input  wire logic [QW-1:0]    in_q_i,
    input  wire logic [QW-1:0]    in_q_j,
    input  wire logic [CNT_W-1:0] div_i,
    input  wire logic [CNT_W-1:0] div_j,
    output logic                  out_valid,
    output logic [CNT_W-1:0]      out_rem_i,
    output logic [CNT_W-1:0]      out_rem_j,
    output logic [QW-1:0]         out_q_i,
    output logic [QW-1:0]         out_q_j
);

    logic             valid_reg;
    logic [CNT_W-1:0] rem_i_reg, rem_j_reg, rem_i_next, rem_j_next;
    logic [QW-1:0]    q_i_reg, q_j_reg, q_i_next, q_j_next;
    logic [CNT_W:0]   t_i, t_j;
    logic             bit_i, bit_j;

    always_comb
    begin
        // the integer step compares without doubling
        t_i = FIRST ? {1'b0, in_rem_i} : {in_rem_i, 1'b0};
        t_j = FIRST ? {1'b0, in_rem_j} : {in_rem_j, 1'b0};
        bit_i = (t_i >= {1'b0, div_i});
        bit_j = (t_j >= {1'b0, div_j});
        rem_i_next = bit_i ? CNT_W'(t_i - {1'b0, div_i}) : t_i[CNT_W-1:0];
        rem_j_next = bit_j ? CNT_W'(t_j - {1'b0, div_j}) : t_j[CNT_W-1:0];
        q_i_next = {in_q_i[QW-2:0], bit_i};
        q_j_next = {in_q_j[QW-2:0], bit_j};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_i_reg <= rem_i_next;
            rem_j_reg <= rem_j_next;
            q_i_reg   <= q_i_next;
            q_j_reg   <= q_j_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_rem_i = rem_i_reg;
    assign out_rem_j = rem_j_reg;
    assign out_q_i   = q_i_reg;
    assign out_q_j   = q_j_reg;

endmodule
`default_nettype wire

@@ design/vsg_qsine.sv @@
// vsg_qsine: four-stage pipelined quarter-wave sine polynomial, Q1.16 in, Q16 out.
// Depends on vsg_pkg for the coefficients.
`default_nettype none
module vsg_qsine
    import vsg_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        en,
    input  wire logic [16:0] x_in,
    output logic [16:0]      s_out
);

    logic [16:0] x1_reg, x2a_reg, x3_reg;
    logic [16:0] sq1_reg, sq2_reg;
    logic [15:0] t1_reg;
    logic [16:0] t2_reg;
    logic [16:0] s_reg;

    logic [33:0] m1;
    logic [29:0] m2;
    logic [32:0] m3;
    logic [33:0] m4;
    logic [16:0] sq_next;
    logic [15:0] t1_next;
    logic [16:0] t2_next, s_next;

    always_comb
    begin
        m1 = 34'(x_in) * 34'(x_in) + 34'd32768;
        sq_next = m1[32:16];
        m2 = 30'(SIN_C) * 30'(sq1_reg) + 30'd32768;
        t1_next = 16'(SIN_B - {3'b0, m2[29:16]});
        m3 = 33'(t1_reg) * 33'(sq2_reg) + 33'd32768;
        t2_next = SIN_A - m3[32:16];
        m4 = 34'(x3_reg) * 34'(t2_reg) + 34'd32768;
        s_next = (m4[33:16] > {1'b0, ONE_Q16}) ? ONE_Q16 : m4[32:16];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x1_reg  <= x_in;
            sq1_reg <= sq_next;
            x2a_reg <= x1_reg;
            sq2_reg <= sq1_reg;
            t1_reg  <= t1_next;
            x3_reg  <= x2a_reg;
            t2_reg  <= t2_next;
            s_reg   <= s_next;
        end
    end

    assign s_out = s_reg;

endmodule
`default_nettype wire

@@ design/uv_sphere_vertex_generator.sv @@
// uv_sphere_vertex_generator: top level of the uv sphere vertex generator.
// Depends on vsg_pkg, vsg_div_cell and vsg_qsine.
`default_nettype none
// One vertex item per clock is taken and one result item per clock is given out. An item
// passes max(ANGLE_BITS,16)+10 register stages (26 at the defaults), the first loaded at
// its accepting edge: a chain of max(ANGLE_BITS,16)+2 division cells forms i/L and j/M
// one quotient bit per cell, then one angle stage, four stages of sine polynomial, a
// quadrant stage, the ring radius multiply stage and the output register, which also
// takes the second multiply. The whole pipeline moves when the output register is empty
// or taken, so a held output stalls input too. Configuration registers are read live by
// the pipeline and must only change while it is empty.
module uv_sphere_vertex_generator
    import vsg_pkg::*;
#(
    parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF,
    parameter int ANGLE_BITS   = ANGLE_BITS_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic [CFG_IW-1:0] cfg_index,
    input  wire logic [15:0]       cfg_data,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    // lon_index[10:0], lat_index[21:11], zero pad
    input  wire logic [23:0]       s_tdata,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    // pos_x[16:0], pos_y[33:17], pos_z[50:34], tex_u[67:51], tex_v[84:68], zero pad
    output logic [87:0]            m_tdata
);

    localparam int FB    = (ANGLE_BITS > 16) ? ANGLE_BITS : 16;
    localparam int T     = FB + 1;
    localparam int NCELL = T + 1;
    localparam int QW    = NCELL;
    localparam int SD    = 4;
    localparam logic [ANGLE_BITS-1:0] QUARTER = ANGLE_BITS'(1) << (ANGLE_BITS - 2);

    // configuration
    logic [CNT_W-1:0] lon_cnt_reg, lat_cnt_reg;
    logic [RAD_W-1:0] radius_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lon_cnt_reg <= LON_COUNT_RST;
            lat_cnt_reg <= LAT_COUNT_RST;
            radius_reg  <= RADIUS_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_LON_COUNT: lon_cnt_reg <= cfg_data[CNT_W-1:0];
                CFG_LAT_COUNT: lat_cnt_reg <= cfg_data[CNT_W-1:0];
                CFG_RADIUS:    radius_reg  <= cfg_data;
                default:       ;
            endcase
        end
    end

    logic [CNT_W-1:0] lc, mc, i_in, j_in, i_cl, j_cl;
    logic             en;

    assign lc   = eff_count(lon_cnt_reg, MAX_SEGMENTS);
    assign mc   = eff_count(lat_cnt_reg, MAX_SEGMENTS);
    assign i_in = s_tdata[10:0];
    assign j_in = s_tdata[21:11];
    assign i_cl = (i_in > lc) ? lc : i_in;
    assign j_cl = (j_in > mc) ? mc : j_in;

    logic m_valid_reg;
    assign en       = !m_valid_reg || m_tready;
    assign s_tready = en;

    // division chain
    logic             v_ch [NCELL+1];
    logic [CNT_W-1:0] ri_ch [NCELL+1];
    logic [CNT_W-1:0] rj_ch [NCELL+1];
    logic [QW-1:0]    qi_ch [NCELL+1];
    logic [QW-1:0]    qj_ch [NCELL+1];

    assign v_ch[0]  = s_tvalid;
    assign ri_ch[0] = i_cl;
    assign rj_ch[0] = j_cl;
    assign qi_ch[0] = '0;
    assign qj_ch[0] = '0;

    genvar k;
    generate
        for (k = 0; k < NCELL; k++)
        begin : g_cell
            vsg_div_cell #(
                .QW    (QW),
                .FIRST (k == 0)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .en        (en),
                .in_valid  (v_ch[k]),
                .in_rem_i  (ri_ch[k]),
                .in_rem_j  (rj_ch[k]),
                .in_q_i    (qi_ch[k]),
                .in_q_j    (qj_ch[k]),
                .div_i     (lc),
                .div_j     (mc),
                .out_valid (v_ch[k+1]),
                .out_rem_i (ri_ch[k+1]),
                .out_rem_j (rj_ch[k+1]),
                .out_q_i   (qi_ch[k+1]),
                .out_q_j   (qj_ch[k+1])
            );
        end
    endgenerate

    // angles and texture coordinates from the quotients
    logic [QW-1:0]           qi, qj, th_sh, ph_sh, u_sh, v_sh;
    logic [ANGLE_BITS+1:0]   th_rnd, ph_rnd;
    logic [ANGLE_BITS-1:0]   theta, phi;
    logic [18:0]             u_rnd, v_rnd;
    logic [ANGLE_BITS-3:0]   fr_t, fr_p;
    logic [16:0]             x_t, x_p;

    assign qi     = qi_ch[NCELL];
    assign qj     = qj_ch[NCELL];
    assign th_sh  = qi >> (T - ANGLE_BITS - 1);
    assign ph_sh  = qj >> (T - ANGLE_BITS);
    assign u_sh   = qi >> (T - 17);
    assign v_sh   = qj >> (T - 17);
    assign th_rnd = th_sh[ANGLE_BITS+1:0] + 1'b1;
    assign ph_rnd = ph_sh[ANGLE_BITS+1:0] + 1'b1;
    assign theta  = th_rnd[ANGLE_BITS:1];
    // phi is offset by a quarter turn so the south pole sits at index zero
    assign phi    = ph_rnd[ANGLE_BITS:1] - QUARTER;
    assign u_rnd  = {1'b0, u_sh[17:0]} + 19'd1;
    assign v_rnd  = {1'b0, v_sh[17:0]} + 19'd1;
    assign fr_t   = theta[ANGLE_BITS-3:0];
    assign fr_p   = phi[ANGLE_BITS-3:0];

    generate
        if (ANGLE_BITS <= 18)
        begin : g_xup
            assign x_t = 17'(fr_t) << (18 - ANGLE_BITS);
            assign x_p = 17'(fr_p) << (18 - ANGLE_BITS);
        end
        else
        begin : g_xdn
            assign x_t = 17'(fr_t >> (ANGLE_BITS - 18));
            assign x_p = 17'(fr_p >> (ANGLE_BITS - 18));
        end
    endgenerate

    logic        a_valid_reg;
    logic [1:0]  a_qt_reg, a_qp_reg;
    logic [16:0] a_xt_reg, a_xp_reg, a_u_reg, a_v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else if (en)
            a_valid_reg <= v_ch[NCELL];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_qt_reg <= theta[ANGLE_BITS-1:ANGLE_BITS-2];
            a_qp_reg <= phi[ANGLE_BITS-1:ANGLE_BITS-2];
            a_xt_reg <= x_t;
            a_xp_reg <= x_p;
            a_u_reg  <= u_rnd[17:1];
            a_v_reg  <= v_rnd[17:1];
        end
    end

    // sine and cosine of both angles
    logic [16:0] sx_t, sy_t, sx_p, sy_p;

    vsg_qsine u_sx_t (.clk(clk), .en(en), .x_in(a_xt_reg),           .s_out(sx_t));
    vsg_qsine u_sy_t (.clk(clk), .en(en), .x_in(ONE_Q16 - a_xt_reg), .s_out(sy_t));
    vsg_qsine u_sx_p (.clk(clk), .en(en), .x_in(a_xp_reg),           .s_out(sx_p));
    vsg_qsine u_sy_p (.clk(clk), .en(en), .x_in(ONE_Q16 - a_xp_reg), .s_out(sy_p));

    // side delay line matching the sine latency
    logic        d_valid_reg [SD];
    logic [1:0]  d_qt_reg [SD];
    logic [1:0]  d_qp_reg [SD];
    logic [16:0] d_u_reg [SD];
    logic [16:0] d_v_reg [SD];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int n = 0; n < SD; n++)
                d_valid_reg[n] <= 1'b0;
        end
        else if (en)
        begin
            d_valid_reg[0] <= a_valid_reg;
            for (int n = 1; n < SD; n++)
                d_valid_reg[n] <= d_valid_reg[n-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_qt_reg[0] <= a_qt_reg;
            d_qp_reg[0] <= a_qp_reg;
            d_u_reg[0]  <= a_u_reg;
            d_v_reg[0]  <= a_v_reg;
            for (int n = 1; n < SD; n++)
            begin
                d_qt_reg[n] <= d_qt_reg[n-1];
                d_qp_reg[n] <= d_qp_reg[n-1];
                d_u_reg[n]  <= d_u_reg[n-1];
                d_v_reg[n]  <= d_v_reg[n-1];
            end
        end
    end

    // quadrant fold
    logic signed [17:0] st_next, ct_next, sp_next, cp_next;
    logic signed [17:0] sxt_s, syt_s, sxp_s, syp_s;

    assign sxt_s = $signed({1'b0, sx_t});
    assign syt_s = $signed({1'b0, sy_t});
    assign sxp_s = $signed({1'b0, sx_p});
    assign syp_s = $signed({1'b0, sy_p});

    always_comb
    begin
        case (d_qt_reg[SD-1])
            2'd0:    begin st_next = sxt_s;  ct_next = syt_s;  end
            2'd1:    begin st_next = syt_s;  ct_next = -sxt_s; end
            2'd2:    begin st_next = -sxt_s; ct_next = -syt_s; end
            default: begin st_next = -syt_s; ct_next = sxt_s;  end
        endcase
        case (d_qp_reg[SD-1])
            2'd0:    begin sp_next = sxp_s;  cp_next = syp_s;  end
            2'd1:    begin sp_next = syp_s;  cp_next = -sxp_s; end
            2'd2:    begin sp_next = -sxp_s; cp_next = -syp_s; end
            default: begin sp_next = -syp_s; cp_next = sxp_s;  end
        endcase
    end

    logic               f_valid_reg;
    logic signed [17:0] f_st_reg, f_ct_reg, f_sp_reg, f_cp_reg;
    logic [16:0]        f_u_reg, f_v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            f_valid_reg <= 1'b0;
        else if (en)
            f_valid_reg <= d_valid_reg[SD-1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f_st_reg <= st_next;
            f_ct_reg <= ct_next;
            f_sp_reg <= sp_next;
            f_cp_reg <= cp_next;
            f_u_reg  <= d_u_reg[SD-1];
            f_v_reg  <= d_v_reg[SD-1];
        end
    end

    // radius times the latitude terms
    logic signed [35:0] p_rc, p_y;
    logic signed [16:0] r_s;

    assign r_s  = $signed({1'b0, radius_reg});
    assign p_rc = 36'(r_s * f_cp_reg) + 36'sd32768;
    assign p_y  = 36'(r_s * f_sp_reg) + 36'sd32768;

    logic               g_valid_reg;
    logic signed [17:0] g_rc_reg, g_st_reg, g_ct_reg;
    logic signed [19:0] g_y_reg;
    logic [16:0]        g_u_reg, g_v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            g_valid_reg <= 1'b0;
        else if (en)
            g_valid_reg <= f_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            g_rc_reg <= p_rc[33:16];
            g_y_reg  <= p_y[35:16];
            g_st_reg <= f_st_reg;
            g_ct_reg <= f_ct_reg;
            g_u_reg  <= f_u_reg;
            g_v_reg  <= f_v_reg;
        end
    end

    // ring radius times the longitude terms
    logic signed [35:0] p_x, p_z;
    logic signed [20:0] x_full, z_full, y_full;
    logic [87:0]        m_data_next;
    logic [87:0]        m_data_reg;

    assign p_x    = 36'(g_rc_reg * g_ct_reg) + 36'sd32768;
    assign p_z    = 36'(g_rc_reg * g_st_reg) + 36'sd32768;
    assign x_full = {p_x[35], p_x[35:16]};
    assign z_full = 21'sd0 - {p_z[35], p_z[35:16]};
    assign y_full = {g_y_reg[19], g_y_reg};

    assign m_data_next = {3'b0, g_v_reg, g_u_reg,
                          sat_pos(z_full), sat_pos(y_full), sat_pos(x_full)};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else if (en)
            m_valid_reg <= g_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule
`default_nettype wire

@@ design/vsg_checker.sv @@
// vsg_checker: port-level assertions for uv_sphere_vertex_generator, with its bind.
// Imports vsg_pkg.
`default_nettype none
module vsg_checker
    import vsg_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [87:0] m_tdata
);

    // a stalled result item holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled output item changed");

    // input side moves with the output register
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready does not follow output stall");

    // texture coordinates never pass one
    a_tex: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[67:51] <= 17'd65536) && (m_tdata[84:68] <= 17'd65536))
        else $error("texture coordinate above one");

    // positions saturate symmetrically, so the most negative code never shows
    a_sat: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[16:0] != 17'h10000) && (m_tdata[33:17] != 17'h10000)
                     && (m_tdata[50:34] != 17'h10000))
        else $error("position outside saturation range");

endmodule

bind uv_sphere_vertex_generator vsg_checker u_vsg_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire
